[rtl/wrf_pkg.sv]
package wrf_pkg;

    // defaults for the top level parameter and fixed field widths
    localparam int MAX_SIDE_DEF = 256;
    localparam int SAMPLE_BITS  = 8;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int POS_W        = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIDE = 2'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] IMAGE_SIDE_RST  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] WINDOW_SIDE_RST = 9'd3;

endpackage

[rtl/window_range_filter_2d.sv]
// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+----------------------------------
// pixel     | in        | i_pixel_valid / o_pixel_stall    | i_pixel
// result    | out       | o_result_valid / i_result_stall  | o_window_range, o_window_min,
//           |           |                                  | o_window_max, o_top_row, o_left_col
// cfg       | in        | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
// one item at a time, k = window side; while fewer than k rows are stored an item is only stored,
// else it is accepted, then a column scan reads and folds in the k-1 stored rows above it, then a
// column write, and if it ends a window a row scan over the k-1 columns to its left and a result load
// reset is synchronous; it restarts the frame at row 0, column 0; no memory is cleared
// a waiting result sits in its own register, so only the final load waits on i_result_stall
// configuration is taken only while idle and no pixel is offered
module window_range_filter_2d
    import wrf_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // pixel channel
    input  logic                   i_pixel_valid,
    output logic                   o_pixel_stall,
    input  logic [SAMPLE_BITS-1:0] i_pixel,
    // result channel
    output logic                   o_result_valid,
    input  logic                   i_result_stall,
    output logic [SAMPLE_BITS-1:0] o_window_range,
    output logic [SAMPLE_BITS-1:0] o_window_min,
    output logic [SAMPLE_BITS-1:0] o_window_max,
    output logic [POS_W-1:0]       o_top_row,
    output logic [POS_W-1:0]       o_left_col,
    // configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ST_W   = 3;

    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_VRD  = 3'd1;
    localparam logic [ST_W-1:0] S_VACC = 3'd2;
    localparam logic [ST_W-1:0] S_CWR  = 3'd3;
    localparam logic [ST_W-1:0] S_HRD  = 3'd4;
    localparam logic [ST_W-1:0] S_HACC = 3'd5;
    localparam logic [ST_W-1:0] S_OUT  = 3'd6;

    // configuration
    logic [CFG_DATA_W-1:0] r_img_side, r_win_side;
    logic [SIDE_W-1:0]     w_n, w_k;
    logic                  w_cfg_wr;

    // frame position of the next pixel
    logic [IDX_W-1:0]      r_row, r_col;

    // item under work
    logic [ST_W-1:0]        r_state;
    logic [IDX_W-1:0]       r_cur_col;
    logic [IDX_W-1:0]       r_top, r_left;
    logic [IDX_W-1:0]       r_scan;
    logic [SIDE_W-1:0]      r_cnt;
    logic [SAMPLE_BITS-1:0] r_min, r_max;

    // result register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_min, r_out_max;
    logic [IDX_W-1:0]       r_out_top, r_out_left;

    logic                   w_accept;
    logic                   w_col_last, w_row_last;
    logic                   w_rows_ok;
    logic                   w_load;

    logic [SAMPLE_BITS-1:0]   w_ls_rd;
    logic [2*SAMPLE_BITS-1:0] w_cs_rd;

    // side clamp: zero acts as one, above the store size acts as the store size
    always_comb begin
        if (r_img_side == '0) begin
            w_n = SIDE_W'(1);
        end else if (32'(r_img_side) > MAX_SIDE) begin
            w_n = SIDE_W'(MAX_SIDE);
        end else begin
            w_n = SIDE_W'(r_img_side);
        end
        if (r_win_side == '0) begin
            w_k = SIDE_W'(1);
        end else if (32'(r_win_side) > MAX_SIDE) begin
            w_k = SIDE_W'(MAX_SIDE);
        end else begin
            w_k = SIDE_W'(r_win_side);
        end
    end

    assign o_pixel_stall = !i_rst_n || (r_state != S_IDLE);
    // a pixel offered in the same cycle goes first
    assign o_cfg_ready   = i_rst_n && (r_state == S_IDLE) && !i_pixel_valid;
    assign w_accept      = i_pixel_valid && !o_pixel_stall;
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign w_col_last = (SIDE_W'(r_col) + SIDE_W'(1)) >= w_n;
    assign w_row_last = (SIDE_W'(r_row) + SIDE_W'(1)) >= w_n;
    // enough rows stored for a full column of the window
    assign w_rows_ok  = (SIDE_W'(r_row) + SIDE_W'(1)) >= w_k;

    // result load: in S_OUT, while the result register is free or being emptied
    assign w_load = (r_state == S_OUT) && (!r_out_valid || !i_result_stall);

    // line store: one row of 2**IDX_W entries (MAX_SIDE rounded up to a power of two) per image row
    wrf_ram #(
        .ADDR_W (2 * IDX_W),
        .DATA_W (SAMPLE_BITS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_wr_addr ({r_row, r_col}),
        .i_wr_data (i_pixel),
        .i_re      (r_state == S_VRD),
        .i_rd_addr ({r_scan, r_cur_col}),
        .o_rd_data (w_ls_rd)
    );

    // column store: vertical min and max of each column of the current row
    wrf_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (2 * SAMPLE_BITS)
    ) u_col_store (
        .i_clk     (i_clk),
        .i_we      (r_state == S_CWR),
        .i_wr_addr (r_cur_col),
        .i_wr_data ({r_min, r_max}),
        .i_re      (r_state == S_HRD),
        .i_rd_addr (r_scan),
        .o_rd_data (w_cs_rd)
    );

    // configuration registers and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_side <= IMAGE_SIDE_RST;
            r_win_side <= WINDOW_SIDE_RST;
            r_row      <= '0;
            r_col      <= '0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_SIDE: begin
                    r_img_side <= i_cfg_data;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                CFG_WINDOW_SIDE: begin
                    r_win_side <= i_cfg_data;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                default: begin
                    // unknown index, ignored
                end
            endcase
        end else if (w_accept) begin
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_rows_ok) begin
                        r_state <= (w_k == SIDE_W'(1)) ? S_CWR : S_VRD;
                    end
                end
                S_VRD: begin
                    r_state <= S_VACC;
                end
                S_VACC: begin
                    r_state <= (r_cnt == '0) ? S_CWR : S_VRD;
                end
                S_CWR: begin
                    if ((SIDE_W'(r_cur_col) + SIDE_W'(1)) < w_k) begin
                        r_state <= S_IDLE;
                    end else if (w_k == SIDE_W'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HACC;
                end
                S_HACC: begin
                    r_state <= (r_cnt == '0) ? S_OUT : S_HRD;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cur_col <= r_col;
                r_min     <= i_pixel;
                r_max     <= i_pixel;
                // first of the k-1 earlier rows
                r_top     <= r_row + IDX_W'(1) - IDX_W'(w_k);
                r_scan    <= r_row + IDX_W'(1) - IDX_W'(w_k);
                r_cnt     <= w_k - SIDE_W'(1);
            end
            S_VRD: begin
                r_scan <= r_scan + IDX_W'(1);
                r_cnt  <= r_cnt - SIDE_W'(1);
            end
            S_VACC: begin
                if (w_ls_rd < r_min) begin
                    r_min <= w_ls_rd;
                end
                if (w_ls_rd > r_max) begin
                    r_max <= w_ls_rd;
                end
            end
            S_CWR: begin
                // row scan covers the k-1 columns left of this one
                r_left <= r_cur_col + IDX_W'(1) - IDX_W'(w_k);
                r_scan <= r_cur_col + IDX_W'(1) - IDX_W'(w_k);
                r_cnt  <= w_k - SIDE_W'(1);
            end
            S_HRD: begin
                r_scan <= r_scan + IDX_W'(1);
                r_cnt  <= r_cnt - SIDE_W'(1);
            end
            S_HACC: begin
                if (w_cs_rd[2*SAMPLE_BITS-1:SAMPLE_BITS] < r_min) begin
                    r_min <= w_cs_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
                end
                if (w_cs_rd[SAMPLE_BITS-1:0] > r_max) begin
                    r_max <= w_cs_rd[SAMPLE_BITS-1:0];
                end
            end
            default: begin
                // hold
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_min  <= r_min;
            r_out_max  <= r_max;
            r_out_top  <= r_top;
            r_out_left <= r_left;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_window_min   = r_out_min;
    assign o_window_max   = r_out_max;
    assign o_window_range = r_out_max - r_out_min;
    assign o_top_row      = POS_W'(r_out_top);
    assign o_left_col     = POS_W'(r_out_left);

endmodule

[rtl/wrf_ram.sv]
module wrf_ram
    import wrf_pkg::*;
#(
    parameter int ADDR_W = 16,
    parameter int DATA_W = SAMPLE_BITS
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/wrf_checker.sv]
module wrf_checker
    import wrf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_pixel_valid,
    input logic                   o_pixel_stall,
    input logic                   o_result_valid,
    input logic                   i_result_stall,
    input logic [SAMPLE_BITS-1:0] o_window_range,
    input logic [SAMPLE_BITS-1:0] o_window_min,
    input logic [SAMPLE_BITS-1:0] o_window_max,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready
);

    // a stalled result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_stall |=> o_result_valid)
        else $error("result dropped under stall");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_window_min <= o_window_max)
        else $error("window min above max");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_window_range == SAMPLE_BITS'(o_window_max - o_window_min))
        else $error("range mismatch");

    // configuration is only taken between items
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !o_pixel_stall)
        else $error("configuration taken while busy");

    // a pixel and a register write never land on the same edge
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pixel_valid && !o_pixel_stall |-> !(i_cfg_valid && o_cfg_ready))
        else $error("pixel and configuration taken together");

endmodule

bind window_range_filter_2d wrf_checker u_wrf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pixel_valid  (i_pixel_valid),
    .o_pixel_stall  (o_pixel_stall),
    .o_result_valid (o_result_valid),
    .i_result_stall (i_result_stall),
    .o_window_range (o_window_range),
    .o_window_min   (o_window_min),
    .o_window_max   (o_window_max),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);

[bench/window_range_filter_2d_test.sv]
module window_range_filter_2d_test;
    import wrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // register indexes past the end of the list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int LINE_DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int RANDOM_ITEMS = 380;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] win_range;
        logic [SAMPLE_BITS-1:0] win_min;
        logic [SAMPLE_BITS-1:0] win_max;
        logic [POS_W-1:0]       top_row;
        logic [POS_W-1:0]       left_col;
    } t_window_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // all block inputs start at known values
    logic                   pix_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] pix_data = '0;
    logic                   res_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   o_pixel_stall;
    logic                   o_result_valid;
    logic [SAMPLE_BITS-1:0] o_window_range;
    logic [SAMPLE_BITS-1:0] o_window_min;
    logic [SAMPLE_BITS-1:0] o_window_max;
    logic [POS_W-1:0]       o_top_row;
    logic [POS_W-1:0]       o_left_col;
    logic                   o_cfg_ready;

    window_range_filter_2d u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (pix_valid),
        .o_pixel_stall  (o_pixel_stall),
        .i_pixel        (pix_data),
        .o_result_valid (o_result_valid),
        .i_result_stall (res_stall),
        .o_window_range (o_window_range),
        .o_window_min   (o_window_min),
        .o_window_max   (o_window_max),
        .o_top_row      (o_top_row),
        .o_left_col     (o_left_col),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: registers, frame position, line store, row queues
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]  side_reg = IMAGE_SIDE_RST;
    logic [CFG_DATA_W-1:0]  win_reg = WINDOW_SIDE_RST;
    int                     frame_row = 0;
    int                     frame_col = 0;
    logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
    logic [SAMPLE_BITS-1:0] hi_val [MAX_SIDE_DEF];
    int                     hi_col [MAX_SIDE_DEF];
    logic [SAMPLE_BITS-1:0] lo_val [MAX_SIDE_DEF];
    int                     lo_col [MAX_SIDE_DEF];
    int                     hi_head = 0;
    int                     hi_tail = 0;
    int                     lo_head = 0;
    int                     lo_tail = 0;

    t_window_stats pending_windows [$];
    int            fail_count = 0;
    int            random_items = 0;
    bit            no_gaps = 1'b0;
    bit            no_stalls = 1'b0;
    int            stall_left = 0;

    // a side of zero acts as one, anything past the store size saturates
    function automatic int eff_side(input logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return int'(v);
    endfunction

    function automatic void restart_frame();
        frame_row = 0;
        frame_col = 0;
        hi_head = 0;
        hi_tail = 0;
        lo_head = 0;
        lo_tail = 0;
    endfunction

    // one accepted pixel: update the line store and the monotonic queues,
    // queue the window stats when a full window ends here
    function automatic void predict_pixel(input logic [SAMPLE_BITS-1:0] px);
        int n;
        int k;
        int r;
        int c;
        logic [SAMPLE_BITS-1:0] vmin;
        logic [SAMPLE_BITS-1:0] vmax;
        logic [SAMPLE_BITS-1:0] s;
        t_window_stats w;
        n = eff_side(side_reg);
        k = eff_side(win_reg);
        r = (frame_row >= n) ? 0 : frame_row;
        c = (frame_col >= n) ? 0 : frame_col;
        line_mem[r * MAX_SIDE_DEF + c] = px;
        if (r + 1 >= k) begin
            vmin = px;
            vmax = px;
            // vertical min/max of this column over the window rows
            for (int rr = r + 1 - k; rr <= r; rr++) begin
                s = line_mem[rr * MAX_SIDE_DEF + c];
                if (s < vmin)
                    vmin = s;
                if (s > vmax)
                    vmax = s;
            end
            if (c == 0) begin
                hi_head = 0;
                hi_tail = 0;
                lo_head = 0;
                lo_tail = 0;
            end
            while (hi_tail > hi_head && hi_val[hi_tail - 1] <= vmax)
                hi_tail--;
            if (hi_tail < MAX_SIDE_DEF) begin
                hi_val[hi_tail] = vmax;
                hi_col[hi_tail] = c;
                hi_tail++;
            end
            while (hi_head < hi_tail && c - hi_col[hi_head] >= k)
                hi_head++;
            while (lo_tail > lo_head && lo_val[lo_tail - 1] >= vmin)
                lo_tail--;
            if (lo_tail < MAX_SIDE_DEF) begin
                lo_val[lo_tail] = vmin;
                lo_col[lo_tail] = c;
                lo_tail++;
            end
            while (lo_head < lo_tail && c - lo_col[lo_head] >= k)
                lo_head++;
            if (c + 1 >= k) begin
                w.win_min = (lo_head < lo_tail) ? lo_val[lo_head] : '0;
                w.win_max = (hi_head < hi_tail) ? hi_val[hi_head] : '0;
                w.win_range = w.win_max - w.win_min;
                w.top_row = POS_W'(r + 1 - k);
                w.left_col = POS_W'(c + 1 - k);
                pending_windows.insert(pending_windows.size(), w);
            end
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        frame_row = r;
        frame_col = c;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall pattern and the compare against the
    // oldest predicted window
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_window_stats w;
        int pick;
        if (i_rst_n) begin
            // res_stall here is the value the block saw at this edge
            if (o_result_valid && !res_stall) begin
                if (pending_windows.size() == 0) begin
                    $error("unexpected result item: range %0d min %0d max %0d",
                           o_window_range, o_window_min, o_window_max);
                    fail_count++;
                end else begin
                    w = pending_windows[0];
                    pending_windows.delete(0);
                    check_field("window_range", w.win_range, o_window_range);
                    check_field("window_min", w.win_min, o_window_min);
                    check_field("window_max", w.win_max, o_window_max);
                    check_field("top_row", w.top_row, o_top_row);
                    check_field("left_col", w.left_col, o_left_col);
                end
            end
            // pick the next run of stall or no stall, mostly short ones
            if (stall_left > 0) begin
                stall_left--;
            end else if (no_stalls) begin
                res_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    res_stall <= 1'b0;
                    stall_left = $urandom_range(0, 7);
                end else if (pick < 85) begin
                    res_stall <= 1'b1;
                    stall_left = $urandom_range(0, 2);
                end else if (pick < 95) begin
                    res_stall <= 1'b0;
                    stall_left = $urandom_range(20, 80);
                end else begin
                    res_stall <= 1'b1;
                    stall_left = $urandom_range(15, 50);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel side; every task below starts and ends at a rising edge
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int pick;
        if (no_gaps)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high after an accept so back to back items need no
    // second assignment in one step; whoever stops sending lowers it
    task automatic send_pixel(input logic [SAMPLE_BITS-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_data <= px;
        @(posedge i_clk);
        while (o_pixel_stall)
            @(posedge i_clk);
        predict_pixel(px);
    endtask

    // stop sending and wait out every expected item plus the slowest
    // item with no result still being worked on
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge i_clk);
        repeat (4 * eff_side(win_reg) + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_SIDE) begin
            side_reg = val;
            restart_frame();
        end else if (idx == CFG_WINDOW_SIDE) begin
            win_reg = val;
            restart_frame();
        end
    endtask

    task automatic set_sides(input logic [CFG_DATA_W-1:0] img,
                             input logic [CFG_DATA_W-1:0] win);
        write_reg(CFG_IMAGE_SIDE, img);
        write_reg(CFG_WINDOW_SIDE, win);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // small frame with extreme samples, runs past the frame end so the
    // position counters wrap
    task automatic test_small_frame();
        logic [SAMPLE_BITS-1:0] px [11] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128,
                                           8'd1, 8'd254, 8'd255, 8'd0, 8'd7, 8'd255};
        set_sides(9'd3, 9'd2);
        foreach (px[i])
            send_pixel(px[i]);
    endtask

    // zero acts as one and oversize values saturate
    task automatic test_side_clamping();
        set_sides(9'd0, 9'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        set_sides(9'd511, 9'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    // window wider than the image never gives a result
    task automatic test_window_too_big();
        set_sides(9'd2, 9'd3);
        repeat (5) send_pixel(8'($urandom_range(0, 255)));
    endtask

    // writes past the register list must not restart the frame
    task automatic test_spare_index();
        set_sides(9'd3, 9'd2);
        repeat (4) send_pixel(8'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_2, 9'd1);
        write_reg(CFG_SPARE_3, 9'd511);
        repeat (4) send_pixel(8'($urandom_range(0, 255)));
    endtask

    // reset values (256 wide, 3x3) straight after reset, then full width
    // rows with a 1x1 window so the far columns show up
    task automatic test_wide_rows();
        repeat (2 * 256 + 40) send_pixel(8'($urandom_range(0, 255)));
        set_sides(9'd256, 9'd1);
        repeat (260) send_pixel(8'($urandom_range(0, 255)));
        // biggest window on a small image: all items with no result
        set_sides(9'd20, 9'd256);
        repeat (30) send_pixel(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // random frames with random sides, gaps, stalls and sample ranges
    // ------------------------------------------------------------------
    task automatic test_random_frames();
        int pick;
        int img;
        int win;
        int count;
        int top_val;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                img = $urandom_range(1, 10);
                win = $urandom_range(1, img);
            end else if (pick < 9) begin
                img = $urandom_range(2, 16);
                win = $urandom_range(1, 20);
            end else begin
                img = $urandom_range(0, 511);
                win = $urandom_range(0, 511);
            end
            set_sides(CFG_DATA_W'(img), CFG_DATA_W'(win));
            no_gaps = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 4) == 0);
            // narrow sample ranges give lots of ties in the queues
            top_val = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 255;
            count = eff_side(CFG_DATA_W'(img)) * eff_side(CFG_DATA_W'(img));
            count = count * $urandom_range(1, 3) + $urandom_range(0, 5);
            if (count > 300)
                count = 300;
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            repeat (count) begin
                send_pixel(8'($urandom_range(0, top_val)));
                random_items++;
                // hold off until the block has emptied out now and then
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
            end
        end
        no_gaps = 1'b0;
        no_stalls = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wide_rows();
        test_small_frame();
        test_side_clamping();
        test_window_too_big();
        test_spare_index();
        test_random_frames();
        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/wrf_pkg.sv
rtl/wrf_ram.sv
rtl/window_range_filter_2d.sv
rtl/wrf_checker.sv
bench/window_range_filter_2d_test.sv
